/* design/rgb_led_pattern_sequencer_macros.svh */
// Assertion helpers for the LED sequencer; clocked on clk, off during reset.
`ifndef RGB_LED_PATTERN_SEQUENCER_MACROS_SVH
`define RGB_LED_PATTERN_SEQUENCER_MACROS_SVH

`ifndef SYNTH
`define RLPS_ASSERT_HOLDS(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rlps assertion failed");
`define RLPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rlps assertion failed");
`else
`define RLPS_ASSERT_HOLDS(lbl, ante, cons)
`define RLPS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* design/rlps_pkg.sv */
`default_nettype none

package rlps_pkg;

	localparam int STEPS_PER_PATTERN_DEF = 32;
	localparam int PATTERN_COUNT_DEF     = 8;
	localparam int LENGTH_REGS           = 8;

	localparam logic [6:0]  FULL_DUTY = 7'd100;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef enum logic [1:0] {
		MODE_ON        = 2'd0,
		MODE_OFF       = 2'd1,
		MODE_FADE_UP   = 2'd2,
		MODE_FADE_DOWN = 2'd3
	} mode_t;

	// one table step: per channel start duty and mode, plus duration
	typedef struct packed {
		logic [7:0]       duration;
		mode_t [2:0]      mode;
		logic [2:0][6:0]  start;
	} entry_t;

endpackage

`default_nettype wire

/* design/rlps_store.sv */
`default_nettype none

module rlps_store #(
	parameter int DEPTH = rlps_pkg::PATTERN_COUNT_DEF * rlps_pkg::STEPS_PER_PATTERN_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire rlps_pkg::entry_t wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output rlps_pkg::entry_t      rdata_a,
	output rlps_pkg::entry_t      rdata_b
);

	rlps_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

/* design/rgb_led_pattern_sequencer.sv */
`default_nettype none

// RGB LED pattern sequencer. Beats on the slave side are either table writes
// (s_tuser = 1) or 10 ms ticks (s_tuser = 0); every beat yields exactly one
// result beat carrying the three PWM duties, the forced-on flag and the step
// in use. One beat is taken per clock, sustained, while m_tready keeps the
// result register free; the step table lives in a two-read-port memory whose
// reads are launched on the accept edge and whose registered data meets the
// tick in the input stage, then the result register. Pattern lengths must be
// set through the cfg port only while no beat is in flight; the block does not
// enforce this. Table entries never written read back as undefined.
module rgb_led_pattern_sequencer #(
	parameter int STEPS_PER_PATTERN = rlps_pkg::STEPS_PER_PATTERN_DEF,
	parameter int PATTERN_COUNT     = rlps_pkg::PATTERN_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// pattern[2:0] timer_borrowed[3] tenth_tick[4] entry_index[9:5]
	// red_start[16:10] green_start[23:17] blue_start[30:24] red_mode[32:31]
	// green_mode[34:33] blue_mode[36:35] duration[44:37], zero fill above
	input  wire logic [47:0] s_tdata,
	// op[0]
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// red_duty[6:0] green_duty[13:7] blue_duty[20:14] pins_forced_on[21]
	// current_step[27:22], zero fill above
	output logic [31:0]      m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [5:0]  cfg_data
);

	localparam int DEPTH = PATTERN_COUNT * STEPS_PER_PATTERN;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [6:0] STEPS_L = 7'(STEPS_PER_PATTERN);
	localparam logic [4:0] PAT_L   = 5'(PATTERN_COUNT);

	function automatic logic [AW-1:0] addr_of(logic [2:0] p, logic [6:0] s);
		return AW'(p) * AW'(STEPS_PER_PATTERN) + AW'(s);
	endfunction

	function automatic logic [6:0] len_of(logic [2:0] p,
			logic [rlps_pkg::LENGTH_REGS-1:0][5:0] regs);
		logic [6:0] l;
		l = {1'b0, regs[p]};
		if (5'(p) >= PAT_L) begin
			return 7'd0;
		end
		return (l > STEPS_L) ? STEPS_L : l;
	endfunction

	function automatic logic [6:0] sat_duty(logic [6:0] s);
		return (s > rlps_pkg::FULL_DUTY) ? rlps_pkg::FULL_DUTY : s;
	endfunction

	function automatic logic [6:0] chan_duty(rlps_pkg::mode_t m, logic [6:0] s,
			logic [6:0] ramp);
		logic [6:0] d;
		unique case (m)
			rlps_pkg::MODE_FADE_UP:   d = ramp;
			rlps_pkg::MODE_FADE_DOWN: d = rlps_pkg::FULL_DUTY - ramp;
			rlps_pkg::MODE_ON,
			rlps_pkg::MODE_OFF:       d = s;
			default:                  d = s;
		endcase
		return d;
	endfunction

	// input fields
	logic [2:0] in_pat;
	logic       in_borrowed;
	logic       in_tenth;
	logic [4:0] in_idx;
	assign in_pat      = s_tdata[2:0];
	assign in_borrowed = s_tdata[3];
	assign in_tenth    = s_tdata[4];
	assign in_idx      = s_tdata[9:5];

	// state
	logic [rlps_pkg::LENGTH_REGS-1:0][5:0] length_q;
	logic [2:0]       last_q;
	logic             pending_q;
	logic [5:0]       step_q;
	logic [15:0]      fade_q;
	logic [15:0]      tenth_q;
	logic [2:0][6:0]  duty_q;

	// input stage
	logic       valid_s1;
	logic       op_s1;
	logic [2:0] pat_s1;
	logic       borrowed_s1;
	logic       tenth_s1;

	// result stage
	logic            valid_s2;
	logic [2:0][6:0] res_duty_s2;
	logic            res_forced_s2;
	logic [5:0]      res_step_s2;

	logic proc;
	logic s_fire;
	assign proc     = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || proc;
	assign s_fire   = s_tvalid && s_tready;

	// table write
	rlps_pkg::entry_t wr_entry;
	logic             wr_en;
	always_comb begin
		wr_entry.start[0] = sat_duty(s_tdata[16:10]);
		wr_entry.start[1] = sat_duty(s_tdata[23:17]);
		wr_entry.start[2] = sat_duty(s_tdata[30:24]);
		wr_entry.mode[0]  = rlps_pkg::mode_t'(s_tdata[32:31]);
		wr_entry.mode[1]  = rlps_pkg::mode_t'(s_tdata[34:33]);
		wr_entry.mode[2]  = rlps_pkg::mode_t'(s_tdata[36:35]);
		wr_entry.duration = s_tdata[44:37];
	end
	assign wr_en = s_fire && (s_tuser == rlps_pkg::OP_WRITE) &&
		(5'(in_pat) < PAT_L) && ({2'b00, in_idx} < STEPS_L);

	// step processing for the beat in the input stage
	rlps_pkg::entry_t rd_a_s1;
	rlps_pkg::entry_t rd_b_s1;
	logic [2:0]      last_d;
	logic            pending_d;
	logic [5:0]      step_d;
	logic [15:0]     fade_d;
	logic [15:0]     tenth_d;
	logic [2:0][6:0] duty_d;
	logic            forced_d;
	logic [15:0]     fade_inc;
	logic [15:0]     tenth_inc;
	logic [6:0]      len_p;
	logic [6:0]      ramp;
	logic [6:0]      step_nx;
	logic            pend_p;

	always_comb begin
		last_d    = last_q;
		pending_d = pending_q;
		step_d    = step_q;
		fade_d    = fade_q;
		tenth_d   = tenth_q;
		duty_d    = duty_q;
		forced_d  = 1'b0;
		fade_inc  = (fade_q == rlps_pkg::COUNT_MAX) ? fade_q : fade_q + 16'd1;
		tenth_inc = (tenth_s1 && tenth_q != rlps_pkg::COUNT_MAX) ? tenth_q + 16'd1 : tenth_q;
		len_p     = len_of(pat_s1, length_q);
		ramp      = (fade_inc[15:2] > 14'(rlps_pkg::FULL_DUTY)) ?
			rlps_pkg::FULL_DUTY : fade_inc[8:2];
		step_nx   = {1'b0, step_q} + 7'd1;
		pend_p    = pending_q || (pat_s1 != last_q);
		if (proc && op_s1 == rlps_pkg::OP_TICK) begin
			fade_d  = fade_inc;
			tenth_d = tenth_inc;
			if (borrowed_s1) begin
				forced_d = 1'b1;
			end else begin
				last_d    = pat_s1;
				pending_d = pend_p;
				if (len_p != 7'd0) begin
					if (pend_p || {1'b0, step_q} >= len_p) begin
						pending_d = 1'b0;
						step_d    = 6'd0;
						fade_d    = 16'd0;
						tenth_d   = 16'd0;
						duty_d    = rd_a_s1.start;
					end else begin
						for (int c = 0; c < 3; c++) begin
							duty_d[c] = chan_duty(rd_a_s1.mode[c], rd_a_s1.start[c], ramp);
						end
						if (tenth_inc >= {8'd0, rd_a_s1.duration}) begin
							step_d = step_nx[5:0];
							if (step_nx >= len_p) begin
								pending_d = 1'b1;
							end else begin
								fade_d  = 16'd0;
								tenth_d = 16'd0;
								duty_d  = rd_b_s1.start;
							end
						end
					end
				end
			end
		end
	end

	// read launch for the incoming tick, against the state it will see
	logic            pat_ok_i;
	logic            restart_i;
	logic [6:0]      len_i;
	logic [6:0]      step_b;
	logic [AW-1:0]   addr_a;
	logic [AW-1:0]   addr_b;
	always_comb begin
		pat_ok_i  = 5'(in_pat) < PAT_L;
		len_i     = len_of(in_pat, length_q);
		restart_i = pending_d || (in_pat != last_d) || ({1'b0, step_d} >= len_i);
		step_b    = {1'b0, step_d} + 7'd1;
		addr_a    = '0;
		addr_b    = '0;
		if (pat_ok_i) begin
			addr_a = restart_i ? addr_of(in_pat, 7'd0) : addr_of(in_pat, {1'b0, step_d});
			addr_b = (step_b >= STEPS_L) ? addr_of(in_pat, 7'd0) : addr_of(in_pat, step_b);
		end
	end

	rlps_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.we     (wr_en),
		.waddr  (addr_of(in_pat, {2'b00, in_idx})),
		.wdata  (wr_entry),
		.re     (s_fire),
		.raddr_a(addr_a),
		.raddr_b(addr_b),
		.rdata_a(rd_a_s1),
		.rdata_b(rd_b_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q  <= '0;
			last_q    <= 3'd0;
			pending_q <= 1'b1;
			step_q    <= 6'd0;
			fade_q    <= 16'd0;
			tenth_q   <= 16'd0;
			duty_q    <= '0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
		end else begin
			if (cfg_we) begin
				length_q[cfg_index] <= cfg_data;
			end
			last_q    <= last_d;
			pending_q <= pending_d;
			step_q    <= step_d;
			fade_q    <= fade_d;
			tenth_q   <= tenth_d;
			duty_q    <= duty_d;
			if (s_fire) begin
				valid_s1 <= 1'b1;
			end else if (proc) begin
				valid_s1 <= 1'b0;
			end
			if (proc) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_s1       <= s_tuser;
			pat_s1      <= in_pat;
			borrowed_s1 <= in_borrowed;
			tenth_s1    <= in_tenth;
		end
		if (proc) begin
			res_duty_s2   <= duty_d;
			res_forced_s2 <= forced_d;
			res_step_s2   <= step_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, res_step_s2, res_forced_s2,
		res_duty_s2[2], res_duty_s2[1], res_duty_s2[0]};

`include "rgb_led_pattern_sequencer_macros.svh"

	`RLPS_ASSERT_NEXT(a_borrow_keeps_step, proc && op_s1 == rlps_pkg::OP_TICK && borrowed_s1, step_q == $past(step_q) && pending_q == $past(pending_q) && duty_q == $past(duty_q))
	`RLPS_ASSERT_NEXT(a_write_keeps_step, proc && op_s1 == rlps_pkg::OP_WRITE, res_step_s2 == step_q && !res_forced_s2)
	`RLPS_ASSERT_HOLDS(a_step_in_range, 1'b1, 32'(step_q) <= STEPS_PER_PATTERN)

endmodule

`default_nettype wire
